### sv/vehicle_supervisor_fsm_assert.svh
// ----------------------------------------------------------------------------
// vehicle_supervisor_fsm_assert.svh
// Assertion macros for the vehicle supervisor; clocked on clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef VEHICLE_SUPERVISOR_FSM_ASSERT_SVH
`define VEHICLE_SUPERVISOR_FSM_ASSERT_SVH

// same-cycle implication
`define VSF_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("vehicle supervisor check failed");

// next-cycle implication
`define VSF_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("vehicle supervisor check failed");

`endif

### sv/vsf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsf_pkg
// Types, codes and transition tables shared by the vehicle supervisor.
// ----------------------------------------------------------------------------
package vsf_pkg;

	localparam int NUM_BOARDS_DEF = 4;
	localparam int QUEUE_DEPTH    = 2;
	localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

	localparam logic [15:0] CURRENT_LIMIT_RST = 16'hFFFF;
	localparam logic [7:0]  WDOG_RST          = 8'd10;

	typedef enum logic [0:0] {
		REG_CURRENT_LIMIT   = 1'b0,
		REG_WATCHDOG_RELOAD = 1'b1
	} reg_index_t;

	typedef enum logic [3:0] {
		EV_START         = 4'd0,
		EV_ACCEL         = 4'd1,
		EV_BRAKE_RELEASE = 4'd2,
		EV_BRAKE_PUSH    = 4'd3,
		EV_OVER_POWER    = 4'd4,
		EV_RST_FAULT     = 4'd5,
		EV_PLAUS_FAULT   = 4'd6,
		EV_LATCH_FAULT   = 4'd7,
		EV_IMD           = 4'd8,
		EV_BSPD          = 4'd9,
		EV_APPS          = 4'd10,
		EV_BSE           = 4'd11,
		EV_BATTERY       = 4'd12,
		EV_LIVE          = 4'd13
	} event_t;

	typedef enum logic [2:0] {
		ST_WAIT_HB     = 3'd0,
		ST_WAIT_DRIVER = 3'd1,
		ST_DRIVE       = 3'd2,
		ST_START_BRAKE = 3'd3,
		ST_RST_FAULT   = 3'd4,
		ST_LATCHED     = 3'd5
	} drive_state_t;

	typedef enum logic [2:0] {
		BRD_BMS      = 3'd0,
		BRD_SHUTDOWN = 3'd1,
		BRD_MOTOR    = 3'd2,
		BRD_IO       = 3'd3,
		BRD_OTHER    = 3'd4
	} board_t;

	typedef enum logic [2:0] {
		KIND_HEARTBEAT = 3'd0,
		KIND_FAULT     = 3'd1,
		KIND_CURRENT   = 3'd2,
		KIND_PLAUS     = 3'd3,
		KIND_THROTTLE  = 3'd4,
		KIND_BRAKE     = 3'd5,
		KIND_OTHER     = 3'd6
	} kind_t;

	typedef struct packed {
		event_t      ev;
		logic [15:0] throttle;
		logic        last;
	} qentry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	localparam logic [2:0] NEXT_TAB [0:5][0:13] = '{
		'{3'd1, 3'd1, 3'd1, 3'd3, 3'd1, 3'd4, 3'd4,
		  3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd1},
		'{3'd1, 3'd1, 3'd1, 3'd3, 3'd1, 3'd4, 3'd4,
		  3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd1},
		'{3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd4, 3'd4,
		  3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd2},
		'{3'd2, 3'd1, 3'd1, 3'd3, 3'd3, 3'd4, 3'd4,
		  3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd3},
		'{3'd4, 3'd4, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4,
		  3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd4},
		'{3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5,
		  3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5}
	};

	localparam logic [3:0] ACT_TAB [0:5][0:13] = '{
		'{4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0,
		  4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
		'{4'd0, 4'd0, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6,
		  4'd7, 4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd0},
		'{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6,
		  4'd7, 4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd0},
		'{4'd13, 4'd0, 4'd0, 4'd0, 4'd4, 4'd5, 4'd6,
		  4'd7, 4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd0},
		'{4'd0, 4'd0, 4'd2, 4'd3, 4'd4, 4'd5, 4'd0,
		  4'd7, 4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd0},
		'{4'd0, 4'd0, 4'd2, 4'd3, 4'd4, 4'd5, 4'd0,
		  4'd7, 4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd0}
	};

	function automatic logic [2:0] clamp_state(input logic [2:0] st);
		return (st > ST_LATCHED) ? ST_LATCHED : st;
	endfunction

	function automatic logic [3:0] clamp_event(input logic [3:0] ev);
		return (ev > EV_LIVE) ? EV_START : ev;
	endfunction

	function automatic logic [2:0] next_state_f(input logic [2:0] st, input logic [3:0] ev);
		return NEXT_TAB[clamp_state(st)][clamp_event(ev)];
	endfunction

	function automatic logic [3:0] action_f(input logic [2:0] st, input logic [3:0] ev);
		return ACT_TAB[clamp_state(st)][clamp_event(ev)];
	endfunction

endpackage

### sv/vsf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsf_front
// Accepts items, keeps board flags, watchdogs and throttle, and turns each
// item into up to two events, pushed one per cycle while the queue has room.
// ----------------------------------------------------------------------------
module vsf_front #(
	parameter int NUM_BOARDS = vsf_pkg::NUM_BOARDS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [31:0]        s_tdata,   // board_class, message_kind, payload,
	                                      // fault_nonreset_pin, fault_reset_pin, start_button
	input  logic               s_tuser,   // mode
	input  logic [15:0]        current_limit,
	input  logic [7:0]         watchdog_reload,
	input  vsf_pkg::q_status_t q_status,
	output logic               push,
	output vsf_pkg::qentry_t   push_entry,
	output logic               fired
);

	localparam logic [15:0] FAULT_LATCH_MASK = 16'h0068;
	localparam logic [15:0] FAULT_BATTERY    = 16'h0002;
	localparam logic [15:0] FAULT_IMD        = 16'h0004;
	localparam logic [15:0] FAULT_BSPD       = 16'h0001;
	localparam logic [15:0] FAULT_RESETTABLE = 16'h0010;

	logic [2:0]  board_class;
	logic [2:0]  message_kind;
	logic [15:0] payload;
	logic        pin_nonreset;
	logic        pin_reset;
	logic        pin_start;
	logic        accept;

	logic [NUM_BOARDS-1:0] seen_q;
	logic [7:0]            wdog_q [NUM_BOARDS];
	logic [7:0]            wd_dec [NUM_BOARDS];
	logic [15:0]           throttle_q;
	logic                  fired_q;

	logic [1:0]       cnt_s1;
	vsf_pkg::event_t  ev0_s1;
	vsf_pkg::event_t  ev1_s1;
	logic [15:0]      thr_s1;

	logic             all_seen;
	logic             expired;
	logic [1:0]       n_ev;
	vsf_pkg::event_t  ev_a;
	vsf_pkg::event_t  ev_b;
	logic             thr_load;
	logic             is_hb;

	assign board_class  = s_tdata[2:0];
	assign message_kind = s_tdata[5:3];
	assign payload      = s_tdata[21:6];
	assign pin_nonreset = s_tdata[22];
	assign pin_reset    = s_tdata[23];
	assign pin_start    = s_tdata[24];

	assign push     = (cnt_s1 != 2'd0) && !q_status.full;
	assign s_tready = (cnt_s1 == 2'd0) || ((cnt_s1 == 2'd1) && push);
	assign accept   = s_tvalid && s_tready;
	assign fired    = fired_q;
	assign is_hb    = !s_tuser && (message_kind == vsf_pkg::KIND_HEARTBEAT);

	assign push_entry.ev       = ev0_s1;
	assign push_entry.throttle = thr_s1;
	assign push_entry.last     = (cnt_s1 == 2'd1);

	always_comb begin
		expired  = 1'b0;
		all_seen = &seen_q;
		n_ev     = 2'd0;
		ev_a     = vsf_pkg::EV_START;
		ev_b     = vsf_pkg::EV_START;
		thr_load = 1'b0;
		for (int b = 0; b < NUM_BOARDS; b++) begin
			wd_dec[b] = (wdog_q[b] == 8'd0) ? 8'd0 : wdog_q[b] - 8'd1;
			if (wd_dec[b] == 8'd0) begin
				expired = 1'b1;
			end
		end
		if (s_tuser) begin
			if (all_seen) begin
				ev_a = vsf_pkg::EV_LIVE;
				n_ev = 2'd1;
				if (expired || pin_nonreset) begin
					ev_b = vsf_pkg::EV_LATCH_FAULT;
					n_ev = 2'd2;
				end else if (pin_reset) begin
					ev_b = vsf_pkg::EV_RST_FAULT;
					n_ev = 2'd2;
				end else if (pin_start) begin
					ev_b = vsf_pkg::EV_START;
					n_ev = 2'd2;
				end
			end
		end else begin
			case (message_kind)
				vsf_pkg::KIND_FAULT: begin
					if (board_class == vsf_pkg::BRD_SHUTDOWN) begin
						n_ev = 2'd1;
						if ((payload & FAULT_LATCH_MASK) != 16'd0) begin
							ev_a = vsf_pkg::EV_LATCH_FAULT;
						end else if ((payload & FAULT_BATTERY) != 16'd0) begin
							ev_a = vsf_pkg::EV_BATTERY;
						end else if ((payload & FAULT_IMD) != 16'd0) begin
							ev_a = vsf_pkg::EV_IMD;
						end else if ((payload & FAULT_BSPD) != 16'd0) begin
							ev_a = vsf_pkg::EV_BSPD;
						end else if ((payload & FAULT_RESETTABLE) != 16'd0) begin
							ev_a = vsf_pkg::EV_RST_FAULT;
						end else begin
							n_ev = 2'd0;
						end
					end
				end
				vsf_pkg::KIND_CURRENT: begin
					if ((board_class == vsf_pkg::BRD_MOTOR) && (payload >= current_limit)) begin
						ev_a = vsf_pkg::EV_OVER_POWER;
						n_ev = 2'd1;
					end
				end
				vsf_pkg::KIND_PLAUS: begin
					if (board_class == vsf_pkg::BRD_IO) begin
						ev_a = vsf_pkg::EV_PLAUS_FAULT;
						n_ev = 2'd1;
					end
				end
				vsf_pkg::KIND_THROTTLE: begin
					if (board_class == vsf_pkg::BRD_IO) begin
						ev_a     = vsf_pkg::EV_ACCEL;
						n_ev     = 2'd1;
						thr_load = 1'b1;
					end
				end
				vsf_pkg::KIND_BRAKE: begin
					if (board_class == vsf_pkg::BRD_IO) begin
						ev_a = vsf_pkg::EV_BRAKE_PUSH;
						n_ev = 2'd1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q     <= '0;
			throttle_q <= 16'd0;
			fired_q    <= 1'b0;
			cnt_s1     <= 2'd0;
			ev0_s1     <= vsf_pkg::EV_START;
			ev1_s1     <= vsf_pkg::EV_START;
			thr_s1     <= 16'd0;
			for (int b = 0; b < NUM_BOARDS; b++) begin
				wdog_q[b] <= vsf_pkg::WDOG_RST;
			end
		end else begin
			if (accept) begin
				if (n_ev != 2'd0) begin
					fired_q <= 1'b1;
				end
				if (thr_load) begin
					throttle_q <= payload;
				end
				for (int b = 0; b < NUM_BOARDS; b++) begin
					if (s_tuser && all_seen) begin
						wdog_q[b] <= wd_dec[b];
					end else if (is_hb && (board_class == 3'(b))) begin
						if (fired_q) begin
							wdog_q[b] <= watchdog_reload;
						end else begin
							seen_q[b] <= 1'b1;
						end
					end
				end
				cnt_s1 <= n_ev;
				ev0_s1 <= ev_a;
				ev1_s1 <= ev_b;
				thr_s1 <= thr_load ? payload : throttle_q;
			end else if (push) begin
				cnt_s1 <= cnt_s1 - 2'd1;
				ev0_s1 <= ev1_s1;
			end
		end
	end

endmodule

### sv/vsf_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsf_queue
// Short event queue between the front and the back.
// ----------------------------------------------------------------------------
module vsf_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  vsf_pkg::qentry_t   push_entry,
	input  logic               pop,
	output vsf_pkg::qentry_t   head,
	output vsf_pkg::q_status_t status
);

	vsf_pkg::qentry_t            mem_q [vsf_pkg::QUEUE_DEPTH];
	logic [vsf_pkg::QPTR_W-1:0]  wr_ptr_q;
	logic [vsf_pkg::QPTR_W-1:0]  rd_ptr_q;
	logic [vsf_pkg::QCNT_W-1:0]  count_q;

	function automatic logic [vsf_pkg::QPTR_W-1:0] advance(
		input logic [vsf_pkg::QPTR_W-1:0] ptr
	);
		return (ptr == vsf_pkg::QPTR_W'(vsf_pkg::QUEUE_DEPTH - 1)) ? '0 : ptr + 1'b1;
	endfunction

	assign head         = mem_q[rd_ptr_q];
	assign status.full  = (count_q == vsf_pkg::QCNT_W'(vsf_pkg::QUEUE_DEPTH));
	assign status.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= advance(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= advance(rd_ptr_q);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### sv/vsf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsf_back
// Drive state machine: takes events from the queue, looks up next state and
// action, and holds each result in the output register.
// ----------------------------------------------------------------------------
module vsf_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  vsf_pkg::q_status_t    q_status,
	input  vsf_pkg::qentry_t      head,
	output logic                  pop,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [31:0]           m_tdata,  // event_code, new_state, action_code,
	                                        // throttle_value
	output logic                  m_tlast,
	output vsf_pkg::drive_state_t drive_state
);

	vsf_pkg::drive_state_t state_q;
	vsf_pkg::drive_state_t state_d;
	logic [3:0]            act_d;

	logic        valid_q;
	logic [3:0]  ev_q;
	logic [2:0]  st_q;
	logic [3:0]  act_q;
	logic [15:0] thr_q;
	logic        last_q;

	assign m_tvalid    = valid_q;
	assign m_tdata     = {5'd0, thr_q, act_q, st_q, ev_q};
	assign m_tlast     = last_q;
	assign drive_state = state_q;

	always_comb begin
		pop     = !q_status.empty && (!valid_q || m_tready);
		state_d = state_q;
		act_d   = 4'd0;
		if (pop) begin
			state_d = vsf_pkg::drive_state_t'(vsf_pkg::next_state_f(state_q, head.ev));
			act_d   = vsf_pkg::action_f(state_q, head.ev);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vsf_pkg::ST_WAIT_HB;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (pop) begin
				valid_q <= 1'b1;
			end else if (m_tready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			ev_q   <= head.ev;
			st_q   <= state_d;
			act_q  <= act_d;
			thr_q  <= head.throttle;
			last_q <= head.last;
		end
	end

endmodule

### sv/vehicle_supervisor_fsm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vehicle_supervisor_fsm
// Supervisor for a six-state vehicle drive: bus messages and ticks in,
// event, next state and action out.
// ----------------------------------------------------------------------------
// An item is taken every cycle when it gives at most one result and results
// are collected; a tick that gives two results holds the input until both
// events are pushed, as the front writes one event per cycle into the
// two-entry event queue while it has room. A result passes the front
// register, the queue and the output register in that order after the edge
// that takes its item. The output register lets the block take new items
// while a result waits to be collected.
module vehicle_supervisor_fsm #(
	parameter int NUM_BOARDS = vsf_pkg::NUM_BOARDS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // board_class, message_kind, payload,
	                               // fault_nonreset_pin, fault_reset_pin, start_button
	input  logic        s_tuser,   // mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // event_code, new_state, action_code, throttle_value
	output logic        m_tlast,   // last
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	`include "vehicle_supervisor_fsm_assert.svh"

	logic [15:0] current_limit_q;
	logic [7:0]  watchdog_reload_q;

	logic                  q_push;
	logic                  q_pop;
	vsf_pkg::qentry_t      q_in;
	vsf_pkg::qentry_t      q_head;
	vsf_pkg::q_status_t    q_status;
	logic                  ev_fired;
	vsf_pkg::drive_state_t drive_state;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			current_limit_q   <= vsf_pkg::CURRENT_LIMIT_RST;
			watchdog_reload_q <= vsf_pkg::WDOG_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				vsf_pkg::REG_CURRENT_LIMIT:   current_limit_q   <= cfg_data;
				vsf_pkg::REG_WATCHDOG_RELOAD: watchdog_reload_q <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	vsf_front #(
		.NUM_BOARDS(NUM_BOARDS)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.s_tuser        (s_tuser),
		.current_limit  (current_limit_q),
		.watchdog_reload(watchdog_reload_q),
		.q_status       (q_status),
		.push           (q_push),
		.push_entry     (q_in),
		.fired          (ev_fired)
	);

	vsf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_entry(q_in),
		.pop       (q_pop),
		.head      (q_head),
		.status    (q_status)
	);

	vsf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_status   (q_status),
		.head       (q_head),
		.pop        (q_pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.drive_state(drive_state)
	);

	`VSF_ASSERT_IMP(a_queue_no_overflow, q_push, !q_status.full)
	`VSF_ASSERT_IMP(a_queue_no_underflow, q_pop, !q_status.empty)
	`VSF_ASSERT_IMP(a_state_after_event, drive_state != vsf_pkg::ST_WAIT_HB, ev_fired)
	`VSF_ASSERT_NXT(a_pop_fills_output, q_pop, m_tvalid)

endmodule

### tb/vehicle_supervisor_fsm_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vehicle_supervisor_fsm_tb
// Self-checking bench for the vehicle supervisor. Bus messages and ticks are
// streamed in with random gaps while results are collected under random
// back-pressure. A local model of the drive state, board flags, watchdogs and
// stored throttle predicts every event result, which is checked field by
// field in arrival order. Directed bring-up and fault cases come first, then
// random traffic under several register settings, latched faults, any traffic.
// ----------------------------------------------------------------------------
module vehicle_supervisor_fsm_tb;

	localparam int NBOARDS       = vsf_pkg::NUM_BOARDS_DEF;
	localparam int SETTLE_CYCLES = 8;
	localparam int DRAIN_CYCLES  = 12;
	localparam int STUCK_LIMIT   = 5000;
	localparam int HOLD_CYCLES   = 400;

	localparam logic [15:0] FAULT_LATCH_MASK = 16'h0068;
	localparam logic [15:0] FAULT_TRIP_MASK  = 16'h006F;
	localparam int FB_BSPD    = 0;
	localparam int FB_BATTERY = 1;
	localparam int FB_IMD     = 2;
	localparam int FB_RESET   = 4;
	localparam logic [2:0] KIND_UNUSED  = 3'd7;
	localparam logic [2:0] BOARD_TOP    = 3'd7;

	localparam logic [2:0] NEXT_ST [6][14] = '{
		'{3'd1, 3'd1, 3'd1, 3'd3, 3'd1, 3'd4, 3'd4, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd1},
		'{3'd1, 3'd1, 3'd1, 3'd3, 3'd1, 3'd4, 3'd4, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd1},
		'{3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd4, 3'd4, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd2},
		'{3'd2, 3'd1, 3'd1, 3'd3, 3'd3, 3'd4, 3'd4, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd3},
		'{3'd4, 3'd4, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd4},
		'{3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5}
	};

	localparam logic [3:0] ACT_CODE [6][14] = '{
		'{4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0,
		  4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
		'{4'd0, 4'd0, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6,
		  4'd7, 4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd0},
		'{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6,
		  4'd7, 4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd0},
		'{4'd13, 4'd0, 4'd0, 4'd0, 4'd4, 4'd5, 4'd6,
		  4'd7, 4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd0},
		'{4'd0, 4'd0, 4'd2, 4'd3, 4'd4, 4'd5, 4'd0,
		  4'd7, 4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd0},
		'{4'd0, 4'd0, 4'd2, 4'd3, 4'd4, 4'd5, 4'd0,
		  4'd7, 4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd0}
	};

	typedef struct {
		logic        mode;
		logic [2:0]  board;
		logic [2:0]  kind;
		logic [15:0] payload;
		logic        pin_nr;
		logic        pin_rst;
		logic        pin_start;
	} bus_item_t;

	typedef struct {
		logic [3:0]  ev;
		logic [2:0]  st;
		logic [3:0]  act;
		logic [15:0] thr;
		logic        last;
	} event_rec_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;   // board_class, message_kind, payload,
	                        // fault_nonreset_pin, fault_reset_pin, start_button
	logic        s_tuser;   // mode
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;   // event_code, new_state, action_code, throttle_value
	logic        m_tlast;   // last
	logic        cfg_we;
	logic [0:0]  cfg_index;
	logic [15:0] cfg_data;

	// model state
	logic [2:0]  drive_st;
	logic        board_up [NBOARDS];
	logic [7:0]  wdog [NBOARDS];
	logic [15:0] thr_store;
	logic [15:0] lim_reg;
	logic [7:0]  reload_reg;

	event_rec_t expected_events [$];
	int errors = 0;
	int stuck_cycles = 0;
	int sink_hold = 0;
	int sink_gap = 0;
	bit burst = 1'b0;

	vehicle_supervisor_fsm dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [15:0] rand16();
		return 16'($urandom);
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (burst || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic bus_item_t mk_msg(input logic [2:0] board, input logic [2:0] kind,
	                                     input logic [15:0] payload);
		bus_item_t it;
		it.mode      = 1'b0;
		it.board     = board;
		it.kind      = kind;
		it.payload   = payload;
		it.pin_nr    = 1'($urandom);
		it.pin_rst   = 1'($urandom);
		it.pin_start = 1'($urandom);
		return it;
	endfunction

	function automatic bus_item_t mk_tick(input logic nr, input logic rst, input logic start);
		bus_item_t it;
		it.mode      = 1'b1;
		it.board     = 3'($urandom);
		it.kind      = 3'($urandom);
		it.payload   = rand16();
		it.pin_nr    = nr;
		it.pin_rst   = rst;
		it.pin_start = start;
		return it;
	endfunction

	function automatic logic [31:0] pack_item(input bus_item_t it);
		return {7'd0, it.pin_start, it.pin_rst, it.pin_nr, it.payload, it.kind, it.board};
	endfunction

	function automatic void reset_model();
		drive_st   = vsf_pkg::ST_WAIT_HB;
		thr_store  = '0;
		lim_reg    = vsf_pkg::CURRENT_LIMIT_RST;
		reload_reg = vsf_pkg::WDOG_RST;
		for (int b = 0; b < NBOARDS; b++) begin
			board_up[b] = 1'b0;
			wdog[b]     = vsf_pkg::WDOG_RST;
		end
	endfunction

	function automatic void fire(input logic [3:0] ev, input logic is_last);
		event_rec_t r;
		logic [2:0] s;
		s        = (drive_st > vsf_pkg::ST_LATCHED) ? vsf_pkg::ST_LATCHED : drive_st;
		r.ev     = ev;
		r.act    = ACT_CODE[s][ev];
		drive_st = NEXT_ST[s][ev];
		r.st     = drive_st;
		r.thr    = thr_store;
		r.last   = is_last;
		expected_events.push_back(r);
	endfunction

	function automatic void predict_events(input bus_item_t it);
		bit all_up;
		bit expired;
		bit second;
		logic [3:0] ev2;
		all_up  = 1'b1;
		expired = 1'b0;
		second  = 1'b1;
		ev2     = vsf_pkg::EV_START;
		if (it.mode) begin
			for (int b = 0; b < NBOARDS; b++)
				all_up &= board_up[b];
			if (all_up) begin
				for (int b = 0; b < NBOARDS; b++) begin
					if (wdog[b] > 0)
						wdog[b]--;
					if (wdog[b] == 0)
						expired = 1'b1;
				end
				if (expired || it.pin_nr)
					ev2 = vsf_pkg::EV_LATCH_FAULT;
				else if (it.pin_rst)
					ev2 = vsf_pkg::EV_RST_FAULT;
				else if (it.pin_start)
					ev2 = vsf_pkg::EV_START;
				else
					second = 1'b0;
				fire(vsf_pkg::EV_LIVE, !second);
				if (second)
					fire(ev2, 1'b1);
			end
		end else if (it.kind == vsf_pkg::KIND_HEARTBEAT) begin
			for (int b = 0; b < NBOARDS; b++) begin
				if (it.board == 3'(b)) begin
					if (drive_st == vsf_pkg::ST_WAIT_HB)
						board_up[b] = 1'b1;
					else
						wdog[b] = reload_reg;
				end
			end
		end else if (it.board == vsf_pkg::BRD_SHUTDOWN && it.kind == vsf_pkg::KIND_FAULT) begin
			if ((it.payload & FAULT_LATCH_MASK) != 0)
				fire(vsf_pkg::EV_LATCH_FAULT, 1'b1);
			else if (it.payload[FB_BATTERY])
				fire(vsf_pkg::EV_BATTERY, 1'b1);
			else if (it.payload[FB_IMD])
				fire(vsf_pkg::EV_IMD, 1'b1);
			else if (it.payload[FB_BSPD])
				fire(vsf_pkg::EV_BSPD, 1'b1);
			else if (it.payload[FB_RESET])
				fire(vsf_pkg::EV_RST_FAULT, 1'b1);
		end else if (it.board == vsf_pkg::BRD_MOTOR && it.kind == vsf_pkg::KIND_CURRENT) begin
			if (it.payload >= lim_reg)
				fire(vsf_pkg::EV_OVER_POWER, 1'b1);
		end else if (it.board == vsf_pkg::BRD_IO) begin
			case (it.kind)
				vsf_pkg::KIND_PLAUS: fire(vsf_pkg::EV_PLAUS_FAULT, 1'b1);
				vsf_pkg::KIND_THROTTLE: begin
					thr_store = it.payload;
					fire(vsf_pkg::EV_ACCEL, 1'b1);
				end
				vsf_pkg::KIND_BRAKE: fire(vsf_pkg::EV_BRAKE_PUSH, 1'b1);
				default: ;
			endcase
		end
	endfunction

	task automatic send_item(input bus_item_t it);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= it.mode;
		s_tdata  <= pack_item(it);
		do @(posedge clk); while (!s_tready);
		predict_events(it);
	endtask

	// feed starving watchdogs before a tick so the drive stays out of latch
	task automatic send_guarded(input bus_item_t it);
		if (it.mode && drive_st != vsf_pkg::ST_WAIT_HB)
			for (int b = 0; b < NBOARDS; b++)
				if (wdog[b] < 2)
					send_item(mk_msg(3'(b), vsf_pkg::KIND_HEARTBEAT, rand16()));
		send_item(it);
	endtask

	task automatic write_reg(input vsf_pkg::reg_index_t idx, input logic [15:0] val);
		s_tvalid <= 1'b0;
		while (expected_events.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			vsf_pkg::REG_CURRENT_LIMIT:   lim_reg = val;
			vsf_pkg::REG_WATCHDOG_RELOAD: reload_reg = val[7:0];
			default: ;
		endcase
	endtask

	task automatic gen_safe(output bus_item_t it, output bit counts);
		int r;
		int r2;
		logic [2:0] b;
		logic [2:0] k;
		logic [15:0] pl;
		r      = $urandom_range(0, 99);
		r2     = $urandom_range(0, 2);
		counts = 1'b1;
		if (r < 22) begin
			it = mk_msg(3'($urandom_range(0, NBOARDS - 1)), vsf_pkg::KIND_HEARTBEAT, rand16());
		end else if (r < 44) begin
			it = mk_tick(1'b0, $urandom_range(0, 5) == 0, $urandom_range(0, 2) == 0);
		end else if (r < 52) begin
			it = mk_msg(vsf_pkg::BRD_SHUTDOWN, vsf_pkg::KIND_FAULT, rand16() & ~FAULT_TRIP_MASK);
		end else if (r < 62) begin
			pl = (r2 == 0) ? lim_reg : (r2 == 1) ? lim_reg - 16'd1 : rand16();
			it = mk_msg(vsf_pkg::BRD_MOTOR, vsf_pkg::KIND_CURRENT, pl);
		end else if (r < 66) begin
			it = mk_msg(vsf_pkg::BRD_IO, vsf_pkg::KIND_PLAUS, rand16());
		end else if (r < 80) begin
			it = mk_msg(vsf_pkg::BRD_IO, vsf_pkg::KIND_THROTTLE, rand16());
		end else if (r < 90) begin
			it = mk_msg(vsf_pkg::BRD_IO, vsf_pkg::KIND_BRAKE, rand16());
		end else begin
			b = 3'($urandom_range(0, 7));
			k = 3'($urandom_range(1, 7));
			if ((b == vsf_pkg::BRD_SHUTDOWN && k == vsf_pkg::KIND_FAULT)
			    || (b == vsf_pkg::BRD_MOTOR && k == vsf_pkg::KIND_CURRENT)
			    || (b == vsf_pkg::BRD_IO && k >= vsf_pkg::KIND_PLAUS
			        && k <= vsf_pkg::KIND_BRAKE))
				k = vsf_pkg::KIND_OTHER;
			it     = mk_msg(b, k, rand16());
			counts = 1'b0;
		end
	endtask

	task automatic run_safe(input int n, input bit with_hold);
		bus_item_t it;
		bit counts;
		int done_cnt;
		done_cnt = 0;
		while (done_cnt < n) begin
			gen_safe(it, counts);
			send_guarded(it);
			if (counts) begin
				done_cnt++;
				if (done_cnt % 64 == 0)
					burst = ($urandom_range(0, 2) == 0);
				if (with_hold && done_cnt == n / 2)
					sink_hold = HOLD_CYCLES;
			end
		end
		burst = 1'b0;
	endtask

	task automatic run_any(input int n);
		bus_item_t it;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 2) == 0)
				it = mk_tick(1'($urandom), 1'($urandom), 1'($urandom));
			else
				it = mk_msg(($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, BOARD_TOP))
				                                        : 3'($urandom_range(0, 4)),
				            ($urandom_range(0, 14) == 0) ? KIND_UNUSED
				                                         : 3'($urandom_range(0, 6)),
				            rand16());
			send_item(it);
		end
	endtask

	task automatic test_bring_up();
		send_item(mk_tick(1'b1, 1'b1, 1'b1));
		send_item(mk_msg(BOARD_TOP, vsf_pkg::KIND_HEARTBEAT, rand16()));
		send_item(mk_msg(vsf_pkg::BRD_OTHER, vsf_pkg::KIND_HEARTBEAT, 16'hFFFF));
		send_item(mk_msg(vsf_pkg::BRD_BMS, vsf_pkg::KIND_FAULT, 16'hFFFF));
		for (int b = 0; b < NBOARDS - 1; b++)
			send_item(mk_msg(3'(b), vsf_pkg::KIND_HEARTBEAT, 16'h0000));
		send_item(mk_tick(1'b0, 1'b0, 1'b1));
		send_item(mk_msg(3'(NBOARDS - 1), vsf_pkg::KIND_HEARTBEAT, 16'hFFFF));
		send_item(mk_tick(1'b0, 1'b0, 1'b1));
	endtask

	task automatic test_drive_states();
		send_guarded(mk_msg(vsf_pkg::BRD_IO, vsf_pkg::KIND_BRAKE, 16'h0000));
		send_guarded(mk_tick(1'b0, 1'b0, 1'b1));
		send_guarded(mk_msg(vsf_pkg::BRD_IO, vsf_pkg::KIND_THROTTLE, 16'hFFFF));
		send_guarded(mk_msg(vsf_pkg::BRD_MOTOR, vsf_pkg::KIND_CURRENT, 16'hFFFF));
		send_guarded(mk_msg(vsf_pkg::BRD_MOTOR, vsf_pkg::KIND_CURRENT, 16'hFFFE));
		send_guarded(mk_msg(vsf_pkg::BRD_BMS, vsf_pkg::KIND_CURRENT, 16'hFFFF));
		send_guarded(mk_tick(1'b0, 1'b1, 1'b0));
		send_guarded(mk_msg(vsf_pkg::BRD_IO, vsf_pkg::KIND_PLAUS, 16'h0000));
		send_guarded(mk_msg(vsf_pkg::BRD_SHUTDOWN, vsf_pkg::KIND_FAULT, 16'hFF90));
		send_guarded(mk_msg(vsf_pkg::BRD_IO, vsf_pkg::KIND_BRAKE, 16'hFFFF));
		send_guarded(mk_msg(vsf_pkg::BRD_IO, vsf_pkg::KIND_THROTTLE, 16'h0000));
		send_guarded(mk_tick(1'b0, 1'b0, 1'b0));
	endtask

	task automatic test_register_settings();
		run_safe(290, 1'b1);
		write_reg(vsf_pkg::REG_CURRENT_LIMIT, 16'h0000);
		write_reg(vsf_pkg::REG_WATCHDOG_RELOAD, 16'd255);
		run_safe(290, 1'b0);
		write_reg(vsf_pkg::REG_CURRENT_LIMIT, rand16());
		write_reg(vsf_pkg::REG_WATCHDOG_RELOAD, 16'd2);
		run_safe(290, 1'b0);
		write_reg(vsf_pkg::REG_CURRENT_LIMIT, 16'h8000);
		write_reg(vsf_pkg::REG_WATCHDOG_RELOAD, 16'($urandom_range(2, 255)));
		run_safe(290, 1'b0);
	endtask

	task automatic test_latched_faults();
		send_guarded(mk_msg(vsf_pkg::BRD_SHUTDOWN, vsf_pkg::KIND_FAULT, 16'h0080));
		send_guarded(mk_tick(1'b1, 1'b1, 1'b1));
		send_item(mk_msg(vsf_pkg::BRD_SHUTDOWN, vsf_pkg::KIND_FAULT, 16'h0008));
		send_item(mk_msg(vsf_pkg::BRD_SHUTDOWN, vsf_pkg::KIND_FAULT, 16'h0020));
		send_item(mk_msg(vsf_pkg::BRD_SHUTDOWN, vsf_pkg::KIND_FAULT, 16'h0040));
		send_item(mk_msg(vsf_pkg::BRD_SHUTDOWN, vsf_pkg::KIND_FAULT, 16'h0017));
		send_item(mk_msg(vsf_pkg::BRD_SHUTDOWN, vsf_pkg::KIND_FAULT, 16'h0014));
		send_item(mk_msg(vsf_pkg::BRD_SHUTDOWN, vsf_pkg::KIND_FAULT, 16'h0011));
		send_item(mk_msg(vsf_pkg::BRD_SHUTDOWN, vsf_pkg::KIND_FAULT, 16'h0010));
		send_item(mk_msg(vsf_pkg::BRD_IO, KIND_UNUSED, 16'hFFFF));
		// reload of one expires on the very next tick
		write_reg(vsf_pkg::REG_WATCHDOG_RELOAD, 16'd1);
		for (int b = 0; b < NBOARDS; b++)
			send_item(mk_msg(3'(b), vsf_pkg::KIND_HEARTBEAT, rand16()));
		send_item(mk_tick(1'b0, 1'b0, 1'b0));
	endtask

	task automatic test_random_any();
		write_reg(vsf_pkg::REG_CURRENT_LIMIT, 16'h0000);
		run_any(80);
		write_reg(vsf_pkg::REG_WATCHDOG_RELOAD, 16'd255);
		write_reg(vsf_pkg::REG_CURRENT_LIMIT, 16'hFFFF);
		run_any(80);
	endtask

	task automatic flag_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		errors++;
	endtask

	task automatic check_field(input string name, input int got, input int want);
		if (got != want)
			flag_mismatch($sformatf("%s got %0d want %0d", name, got, want));
	endtask

	always @(posedge clk) begin : check_results
		event_rec_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_events.size() == 0) begin
				flag_mismatch($sformatf("unexpected result %h", m_tdata));
			end else begin
				want = expected_events.pop_front();
				check_field("event_code", m_tdata[3:0], want.ev);
				check_field("new_state", m_tdata[6:4], want.st);
				check_field("action_code", m_tdata[10:7], want.act);
				check_field("throttle_value", m_tdata[26:11], want.thr);
				check_field("last", m_tlast, want.last);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (sink_hold > 0) begin
			m_tready <= 1'b0;
			sink_hold--;
		end else if (sink_gap > 0) begin
			m_tready <= 1'b0;
			sink_gap--;
		end else begin
			m_tready <= 1'b1;
			if (!burst && $urandom_range(0, 3) == 0)
				sink_gap = pick_gap();
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;
	end

	initial begin
		while (stuck_cycles < STUCK_LIMIT) @(posedge clk);
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= 1'b0;
		m_tready  <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_index <= vsf_pkg::REG_CURRENT_LIMIT;
		cfg_data  <= '0;
		reset_model();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		test_bring_up();
		test_drive_states();
		test_register_settings();
		test_latched_faults();
		test_random_any();
		s_tvalid <= 1'b0;
		while (expected_events.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
